/* design/msd_pkg.sv */
// Shared types and constants for the multi-server FIFO dispatcher.
// Used by the dispatcher core and the testbench; no dependencies.
`default_nettype none
package msd_pkg;

	// Sizing of the shared queue and the server bank.
	localparam int SERVER_COUNT = 3;
	localparam int QUEUE_DEPTH  = 64;
	localparam int PTR_W        = $clog2(QUEUE_DEPTH);
	localparam int FILL_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int SRV_W        = 2;

	// Field widths of the stream words.
	localparam int ID_W   = 16;
	localparam int LEN_W  = 12;
	localparam int TIME_W = 32;
	localparam int ENTRY_W = ID_W + LEN_W;

	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [FILL_W-1:0] fill_t;
	typedef logic [SRV_W-1:0]  srv_t;
	typedef logic [TIME_W-1:0] time_t;

	typedef enum logic [0:0] {
		CMD_ARRIVE = 1'b0,
		CMD_TICK   = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_QUEUED  = 3'd0,
		ST_DROPPED = 3'd1,
		ST_STARTED = 3'd2,
		ST_SERVING = 3'd3,
		ST_IDLE    = 3'd4
	} status_t;

	typedef enum logic [0:0] {
		FSM_IDLE = 1'b0,
		FSM_TICK = 1'b1
	} fsm_t;

	// Advance a queue pointer with wrap at the queue depth.
	function automatic ptr_t ptr_next(input ptr_t p);
		ptr_t r;
		if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* design/msd_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read.
// A write to the address being read in the same cycle is forwarded to the read data.
`default_nettype none
module msd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read, write-first on an address match.
	always_ff @(posedge clk) begin
		if (we && (waddr == raddr)) begin
			rdata <= wdata;
		end else begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

/* design/fifo_multi_server_dispatcher_core.sv */
// Dispatcher core: one shared job queue in a synchronous RAM feeding a bank of servers.
// An arrive word gives its result word in the cycle after acceptance, so arrive
// words stream at one per cycle while the receiver keeps up. A tick word is accepted,
// then servers are visited one per cycle as the receiver allows, one result word each.
// The queue RAM is read ahead at the next head pointer, so no visit waits on a read.
// Asynchronous reset clears pointers, fill count, servers and time; the RAM needs none.
`default_nettype none
module fifo_multi_server_dispatcher_core import msd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input words.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // job_id [15:0], service_length [27:16], zero pad
	input  wire logic [0:0]  s_tuser,  // command [0]
	input  wire logic        s_tlast,  // last_arrival
	// Result words.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [63:0] m_tdata,  // server_index [1:0], served_id [17:2],
	                                   // finish_time [49:18], queue_fill [56:50],
	                                   // all_done [57], zero pad
	output logic      [2:0]  m_tuser,  // status [2:0]
	output logic             m_tlast   // last result of the input word
);

	// Control and state registers.
	fsm_t              state_q, state_d;
	srv_t              srv_q, srv_d;
	ptr_t              head_q, head_d, tail_q, tail_d;
	fill_t             fill_q, fill_d;
	logic [SERVER_COUNT-1:0] busy_q, busy_d;
	logic [ID_W-1:0]   job_q [SERVER_COUNT];
	logic [ID_W-1:0]   job_d [SERVER_COUNT];
	time_t             end_q [SERVER_COUNT];
	time_t             end_d [SERVER_COUNT];
	time_t             now_q, now_d;
	logic              ended_q, ended_d;

	// Output register.
	logic              out_valid_q;
	srv_t              out_idx_q, out_idx_d;
	status_t           out_status_q, out_status_d;
	logic [ID_W-1:0]   out_id_q, out_id_d;
	time_t             out_fin_q, out_fin_d;
	fill_t             out_fill_q;
	logic              out_done_q, out_done_d;
	logic              out_last_q, out_last_d;
	logic              out_load;

	// Queue RAM ports.
	logic              wr_en;
	logic [ENTRY_W-1:0] wr_data, rd_data;
	logic [ID_W-1:0]   rd_id;
	logic [LEN_W-1:0]  rd_len;

	// Handshake and input fields.
	logic              out_free, in_fire, tick_step, srv_ready;
	cmd_t              in_cmd;
	logic [ID_W-1:0]   in_id;
	logic [LEN_W-1:0]  in_len, len_fix;

	assign in_cmd  = cmd_t'(s_tuser[0]);
	assign in_id   = s_tdata[ID_W-1:0];
	assign in_len  = s_tdata[ID_W+LEN_W-1:ID_W];
	assign len_fix = (in_len == '0) ? LEN_W'(1) : in_len;
	assign wr_data = {len_fix, in_id};
	assign rd_id   = rd_data[ID_W-1:0];
	assign rd_len  = rd_data[ENTRY_W-1:ID_W];

	assign out_free  = !out_valid_q || m_tready;
	assign s_tready  = (state_q == FSM_IDLE) && out_free;
	assign in_fire   = s_tvalid && s_tready;
	assign tick_step = (state_q == FSM_TICK) && out_free;
	assign srv_ready = !busy_q[srv_q] || (end_q[srv_q] == now_q);

	// Queue storage, read ahead at the head pointer of the next cycle.
	msd_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.we    (wr_en),
		.waddr (tail_q),
		.wdata (wr_data),
		.raddr (head_d),
		.rdata (rd_data)
	);

	// Next state, queue updates and the result word.
	always_comb begin
		state_d      = state_q;
		srv_d        = srv_q;
		head_d       = head_q;
		tail_d       = tail_q;
		fill_d       = fill_q;
		busy_d       = busy_q;
		job_d        = job_q;
		end_d        = end_q;
		now_d        = now_q;
		ended_d      = ended_q;
		wr_en        = 1'b0;
		out_load     = 1'b0;
		out_idx_d    = '0;
		out_status_d = ST_QUEUED;
		out_id_d     = '0;
		out_fin_d    = '0;
		out_last_d   = 1'b1;
		case (state_q)
			FSM_IDLE: begin
				if (in_fire) begin
					case (in_cmd)
						CMD_ARRIVE: begin
							out_load = 1'b1;
							out_id_d = in_id;
							if (s_tlast) begin
								ended_d = 1'b1;
							end
							if (fill_q < FILL_W'(QUEUE_DEPTH)) begin
								wr_en        = 1'b1;
								tail_d       = ptr_next(tail_q);
								fill_d       = fill_q + FILL_W'(1);
								out_status_d = ST_QUEUED;
							end else begin
								out_status_d = ST_DROPPED;
							end
						end
						CMD_TICK: begin
							state_d = FSM_TICK;
							srv_d   = '0;
						end
						default: begin
							state_d = FSM_IDLE;
						end
					endcase
				end
			end
			FSM_TICK: begin
				if (tick_step) begin
					out_load   = 1'b1;
					out_idx_d  = srv_q;
					out_last_d = (srv_q == SRV_W'(SERVER_COUNT - 1));
					if (srv_ready) begin
						if (fill_q != '0) begin
							job_d[srv_q]  = rd_id;
							end_d[srv_q]  = now_q + TIME_W'(rd_len);
							busy_d[srv_q] = 1'b1;
							head_d        = ptr_next(head_q);
							fill_d        = fill_q - FILL_W'(1);
							out_status_d  = ST_STARTED;
							out_id_d      = rd_id;
							out_fin_d     = now_q + TIME_W'(rd_len);
						end else begin
							busy_d[srv_q] = 1'b0;
							out_status_d  = ST_IDLE;
						end
					end else begin
						out_status_d = ST_SERVING;
						out_id_d     = job_q[srv_q];
						out_fin_d    = end_q[srv_q];
					end
					if (out_last_d) begin
						state_d = FSM_IDLE;
						now_d   = now_q + TIME_W'(1);
					end else begin
						srv_d = srv_q + SRV_W'(1);
					end
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
		out_done_d = ended_d && (fill_d == '0) && (busy_d == '0);
	end

	// Control state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
			srv_q   <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			fill_q  <= '0;
			busy_q  <= '0;
			now_q   <= '0;
			ended_q <= 1'b0;
			for (int i = 0; i < SERVER_COUNT; i++) begin
				job_q[i] <= '0;
				end_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			srv_q   <= srv_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			fill_q  <= fill_d;
			busy_q  <= busy_d;
			now_q   <= now_d;
			ended_q <= ended_d;
			job_q   <= job_d;
			end_q   <= end_d;
		end
	end

	// Output word valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output word payload.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_idx_q    <= out_idx_d;
			out_status_q <= out_status_d;
			out_id_q     <= out_id_d;
			out_fin_q    <= out_fin_d;
			out_fill_q   <= fill_d;
			out_done_q   <= out_done_d;
			out_last_q   <= out_last_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {6'd0, out_done_q, out_fill_q, out_fin_q, out_id_q, out_idx_q};

	// The fill count never passes the queue depth.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(QUEUE_DEPTH))
		else $error("queue fill count above depth");

	// An empty or full queue has its pointers together.
	a_ptr_meet: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == '0 || fill_q == FILL_W'(QUEUE_DEPTH)) |-> head_q == tail_q)
		else $error("queue pointers disagree with fill count");

	// No input word is taken while servers are being visited.
	a_tick_block: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FSM_TICK |-> !s_tready)
		else $error("input accepted during a tick");

	// The visit of the final server marks the result as last and ends the tick.
	a_tick_last: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_step && srv_q == SRV_W'(SERVER_COUNT - 1)) |=>
			(m_tlast && state_q == FSM_IDLE))
		else $error("tick did not end on its final server");

	// Time advances only as a tick completes.
	a_time_step: assert property (@(posedge clk) disable iff (!arst_n)
		(now_q != $past(now_q)) |-> ($past(state_q) == FSM_TICK && state_q == FSM_IDLE))
		else $error("time advanced outside a tick");

endmodule
`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench for the multi-server FIFO dispatcher core.
// Depends on msd_pkg and fifo_multi_server_dispatcher_core. It drives job and tick words,
// predicts every result word and compares each one field by field.
`default_nettype none
module tb_top import msd_pkg::*; ();

	localparam int HOLD_AT    = 90;      // input words accepted before the long receiver hold
	localparam int HOLD_LEN   = 300;     // cycles the receiver holds off
	localparam int TAIL_WAIT  = 20;      // cycles allowed for stray words at the end
	localparam int CYCLE_CAP  = 200000;  // run timeout in cycles
	localparam int PRINT_CAP  = 40;      // mismatch lines printed at most

	// One input word and one result word, unpacked.
	typedef struct {
		cmd_t        cmd;
		logic [15:0] id;
		logic [11:0] len;
		logic        last_arr;
	} job_word_t;

	typedef struct {
		srv_t        srv;
		status_t     status;
		logic [15:0] id;
		time_t       fin;
		fill_t       fill;
		logic        done;
		logic        last;
	} dispatch_result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic  [31:0] s_tdata = '0;
	logic  [0:0]  s_tuser = '0;
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic  [63:0] m_tdata;
	logic  [2:0]  m_tuser;
	logic         m_tlast;

	job_word_t        queued_words[$];
	dispatch_result_t due_results[$];
	job_word_t        cur_word;
	int               words_in = 0;
	int               bad_fields = 0;
	int               cycles = 0;
	int               hold_left = 0;
	logic             hold_used = 1'b0;
	logic             quiet;

	// Predicted dispatcher state.
	logic [15:0] p_ids  [QUEUE_DEPTH];
	logic [11:0] p_lens [QUEUE_DEPTH];
	ptr_t        p_head = '0;
	ptr_t        p_tail = '0;
	fill_t       p_fill = '0;
	logic        p_busy [SERVER_COUNT] = '{default: 1'b0};
	logic [15:0] p_job  [SERVER_COUNT] = '{default: '0};
	time_t       p_end  [SERVER_COUNT] = '{default: '0};
	time_t       p_now = '0;
	logic        p_ended = 1'b0;

	fifo_multi_server_dispatcher_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Neither side idles while this window of input words passes.
	assign quiet = (words_in >= 30) && (words_in < 80);

	function automatic ptr_t next_slot(input ptr_t p);
		return (p == ptr_t'(QUEUE_DEPTH - 1)) ? ptr_t'(0) : ptr_t'(p + 1'b1);
	endfunction

	function automatic logic sched_done();
		logic d;
		d = p_ended && (p_fill == '0);
		for (int i = 0; i < SERVER_COUNT; i++) begin
			if (p_busy[i]) begin
				d = 1'b0;
			end
		end
		return d;
	endfunction

	// Apply one accepted word to the predicted state and queue its result words.
	task automatic dispatch_word(input job_word_t w);
		logic [11:0]      len;
		dispatch_result_t r;
		int               i;
		if (w.cmd == CMD_ARRIVE) begin
			len = (w.len == '0) ? 12'd1 : w.len;
			if (w.last_arr) begin
				p_ended = 1'b1;
			end
			r.srv = '0;
			r.id = w.id;
			r.fin = '0;
			r.last = 1'b1;
			if (p_fill < QUEUE_DEPTH) begin
				p_ids[p_tail] = w.id;
				p_lens[p_tail] = len;
				p_tail = next_slot(p_tail);
				p_fill = p_fill + 1'b1;
				r.status = ST_QUEUED;
			end else begin
				r.status = ST_DROPPED;
			end
			r.fill = p_fill;
			r.done = sched_done();
			due_results.push_back(r);
		end else begin
			for (i = 0; i < SERVER_COUNT; i++) begin
				r.srv = srv_t'(i);
				r.last = (i == SERVER_COUNT - 1);
				if (!p_busy[i] || p_end[i] == p_now) begin
					if (p_fill != '0) begin
						p_job[i] = p_ids[p_head];
						p_end[i] = p_now + time_t'(p_lens[p_head]);
						p_busy[i] = 1'b1;
						p_head = next_slot(p_head);
						p_fill = p_fill - 1'b1;
						r.status = ST_STARTED;
						r.id = p_job[i];
						r.fin = p_end[i];
					end else begin
						p_busy[i] = 1'b0;
						r.status = ST_IDLE;
						r.id = '0;
						r.fin = '0;
					end
				end else begin
					r.status = ST_SERVING;
					r.id = p_job[i];
					r.fin = p_end[i];
				end
				r.fill = p_fill;
				r.done = sched_done();
				due_results.push_back(r);
			end
			p_now = p_now + 1'b1;
		end
	endtask

	task automatic note_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		if (bad_fields < PRINT_CAP) begin
			$display("cycle %0d: %s differs, got %0h, wanted %0h", cycles, what, got, want);
		end
		bad_fields++;
	endtask

	// Compare one accepted result word with the oldest prediction.
	task automatic check_result();
		dispatch_result_t want;
		if (due_results.size() == 0) begin
			note_mismatch("unpredicted result word", m_tdata, 0);
			return;
		end
		want = due_results.pop_front();
		if (m_tdata[1:0] != want.srv) note_mismatch("server_index", m_tdata[1:0], want.srv);
		if (m_tuser != want.status) note_mismatch("status", m_tuser, want.status);
		if (m_tdata[17:2] != want.id) note_mismatch("served_id", m_tdata[17:2], want.id);
		if (m_tdata[49:18] != want.fin) note_mismatch("finish_time", m_tdata[49:18], want.fin);
		if (m_tdata[56:50] != want.fill) note_mismatch("queue_fill", m_tdata[56:50], want.fill);
		if (m_tdata[57] != want.done) note_mismatch("all_done", m_tdata[57], want.done);
		if (m_tlast != want.last) note_mismatch("last", m_tlast, want.last);
	endtask

	// Driver: predicts each accepted word, then offers the next one or idles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			s_tlast <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				dispatch_word(cur_word);
				words_in <= words_in + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (queued_words.size() != 0 && (quiet || $urandom_range(0, 99) >= 25)) begin
					cur_word = queued_words.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {4'b0, cur_word.len, cur_word.id};
					s_tuser <= cur_word.cmd;
					s_tlast <= cur_word.last_arr;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold, started once during the arrival burst.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_used <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_used && words_in >= HOLD_AT) begin
			hold_left <= HOLD_LEN;
			hold_used <= 1'b1;
		end
	end

	// Monitor: checks each accepted result word and varies the ready.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				check_result();
			end
			m_tready <= (hold_left == 0) && (quiet || $urandom_range(0, 99) >= 25);
		end
	end

	// Timeout.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_CAP) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic push_arrive(input logic [15:0] id, input logic [11:0] len,
			input logic last_arr);
		job_word_t w;
		w.cmd = CMD_ARRIVE;
		w.id = id;
		w.len = len;
		w.last_arr = last_arr;
		queued_words.push_back(w);
	endtask

	// Tick words carry random content in the fields the block ignores.
	task automatic push_tick();
		job_word_t w;
		w.cmd = CMD_TICK;
		w.id = 16'($urandom);
		w.len = 12'($urandom);
		w.last_arr = 1'($urandom);
		queued_words.push_back(w);
	endtask

	task automatic push_mix(input int n, input int tick_pct, input int max_len);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 99) < tick_pct) begin
				push_tick();
			end else begin
				push_arrive(16'($urandom), 12'($urandom_range(0, max_len)), 1'b0);
			end
		end
	endtask

	task automatic wait_words_sent();
		while (queued_words.size() != 0 || s_tvalid) begin
			@(negedge clk);
		end
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// Directed: idle servers, zero and extreme ids and lengths, job handover.
		push_tick();
		push_arrive(16'h0000, 12'd0, 1'b0);
		push_arrive(16'hFFFF, 12'd1, 1'b0);
		push_arrive(16'h1234, 12'd2, 1'b0);
		push_arrive(16'h5A5A, 12'd3, 1'b0);
		push_tick();
		push_tick();
		push_arrive(16'hA5A5, 12'd0, 1'b0);
		push_tick();
		push_tick();
		push_arrive(16'h0001, 12'd5, 1'b0);
		push_arrive(16'h8000, 12'd1, 1'b0);
		push_arrive(16'h7FFF, 12'd2, 1'b0);
		push_arrive(16'h00FF, 12'd1, 1'b0);
		repeat (8) push_tick();

		// Random mix with short service lengths.
		push_mix(40, 50, 5);

		// Burst that fills the queue; the final words are dropped, one at full length.
		for (int k = 0; k < 69; k++) begin
			push_arrive(16'($urandom), 12'($urandom_range(0, 2)), 1'b0);
		end
		push_arrive(16'hFFFF, 12'hFFF, 1'b0);

		// Drain mostly with ticks.
		push_mix(45, 80, 3);

		// Last arrival, an arrival after it, then tick until everything is done.
		push_arrive(16'($urandom), 12'($urandom_range(1, 3)), 1'b1);
		push_arrive(16'h0000, 12'd0, 1'b0);
		push_arrive(16'($urandom), 12'd1, 1'b1);
		wait_words_sent();
		while (!sched_done()) begin
			repeat (4) push_tick();
			wait_words_sent();
		end
		repeat (3) push_tick();
		wait_words_sent();

		while (due_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (TAIL_WAIT) @(negedge clk);
		if (bad_fields == 0 && due_results.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
`default_nettype wire

/* files.f */
design/msd_pkg.sv
design/msd_ram.sv
design/fifo_multi_server_dispatcher_core.sv
dv/tb_top.sv
